// ----- rtl/core/serial_attribute_video_raster_top_assert.svh -----
// Assertion macros for the serial attribute video raster block.
// Used by the port checker; no other dependencies.
`ifndef SERIAL_ATTRIBUTE_VIDEO_RASTER_TOP_ASSERT_SVH
`define SERIAL_ATTRIBUTE_VIDEO_RASTER_TOP_ASSERT_SVH
// Assert an implication under active-low reset.
`define SAVR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Assert an implication whose consequent holds in the cycle after the antecedent.
`define SAVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/savr_pkg.sv -----
// Package for the serial attribute video raster block.
// Holds shared constants, types and the pixel expansion function; no dependencies.
package savr_pkg;
  localparam int MemAddrBits  = 16;
  localparam int CellsPerLine = 40;
  localparam int CellBits     = 6;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_RASTER = 1'b1;

  localparam logic [1:0] REG_HSCR = 2'd0;
  localparam logic [1:0] REG_HCHR = 2'd1;
  localparam logic [1:0] REG_TSCR = 2'd2;
  localparam logic [1:0] REG_TCHR = 2'd3;

  localparam logic [1:0] ATTR_FG   = 2'd0;
  localparam logic [1:0] ATTR_TEXT = 2'd1;
  localparam logic [1:0] ATTR_BG   = 2'd2;
  localparam logic [1:0] ATTR_MODE = 2'd3;

  // Job handed from the front to the back.
  typedef struct packed {
    logic                   is_write;
    logic [MemAddrBits-1:0] addr;
    logic [7:0]             data;
  } savr_job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCR, ST_CHR, ST_EMIT, ST_OUTW
  } savr_state_t;

  typedef struct packed {
    logic [17:0] pixels;
    logic [7:0]  line;
    logic [5:0]  column;
    logic        visible;
    logic        frame_start;
    logic        last;
  } savr_res_t;

  function automatic logic [17:0] make_pixels(input logic [5:0] bits,
                                              input logic [2:0] fg,
                                              input logic [2:0] bg);
    logic [17:0] px;
    px = '0;
    for (int i = 0; i < 6; i++) begin
      px[17-3*i -: 3] = bits[5-i] ? fg : bg;
    end
    return px;
  endfunction
endpackage

// ----- rtl/core/savr_front.sv -----
// Front end: accepts input items and queues them as jobs.
// Depends on savr_pkg.
module savr_front import savr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_cmd,
  input  logic [15:0]            in_mem_addr,
  input  logic [7:0]             in_mem_data,
  output logic                   q_valid,
  input  logic                   q_ready,
  output savr_job_t              q_job
);
  savr_job_t  slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_job    = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r].is_write <= (in_cmd == CMD_WRITE);
      slot_r[wp_r].addr     <= in_mem_addr[MemAddrBits-1:0];
      slot_r[wp_r].data     <= in_mem_data;
    end
  end
endmodule

// ----- rtl/core/savr_back.sv -----
// Back end: video memory, raster counter and per-cell renderer.
// Depends on savr_pkg.
module savr_back import savr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  savr_job_t   q_job,
  input  logic [15:0] hscr,
  input  logic [15:0] hchr,
  input  logic [15:0] tscr,
  input  logic [15:0] tchr,
  output logic        res_valid,
  input  logic        res_ready,
  output savr_res_t   res
);
  logic [7:0] mem [2**MemAddrBits];
  logic [7:0] rd_r;

  savr_state_t state_r, state_nxt;
  logic [8:0]  raster_r, raster_nxt;
  logic [4:0]  frame_r, frame_nxt;
  logic        rate50_r, rate50_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [2:0]  tattr_r, tattr_nxt;
  logic [2:0]  fg_r, fg_nxt, bg_r, bg_nxt;
  logic [5:0]  blink_r, blink_nxt;
  logic [2:0]  chl_r, chl_nxt;
  logic [7:0]  y_r, y_nxt;
  logic [5:0]  col_r, col_nxt;
  logic        wrap_r, wrap_nxt;
  logic [7:0]  c_r, c_nxt;
  logic [5:0]  data_r, data_nxt;
  savr_res_t   res_r, res_nxt;
  logic        rv_r, rv_nxt;

  logic        rd_en;
  logic [MemAddrBits-1:0] rd_addr;
  logic        hires;
  logic [15:0] scr_addr, chr_addr, cb;
  logic [8:0]  maxr, nr;
  logic [13:0] y40;
  logic [15:0] cy40;
  logic [5:0]  mask;
  logic [2:0]  f, g;

  assign res_valid = rv_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (q_valid && q_ready && q_job.is_write) mem[q_job.addr] <= q_job.data;
    if (rd_en) rd_r <= mem[rd_addr];
  end

  always_comb begin
    hires    = (y_r < 8'd200) && mode_r[2];
    y40      = {6'd0, y_r} * 14'd40;
    cy40     = 16'(y_r[7:3]) * 16'd40;
    scr_addr = (hires ? (hscr + 16'(y40)) : (tscr + cy40)) + 16'(col_r);
    cb       = (mode_r[2] ? hchr : tchr) + (tattr_r[0] ? 16'd1024 : 16'd0);
    chr_addr = cb + {5'd0, rd_r[6:0], 3'd0} + 16'(chl_r);
    mask     = frame_r[4] ? 6'h3f : blink_r;
    f        = c_r[7] ? ~fg_r : fg_r;
    g        = c_r[7] ? ~bg_r : bg_r;
    maxr     = rate50_r ? 9'd312 : 9'd262;
    nr       = raster_r + 9'd1;
  end

  always_comb begin
    state_nxt = state_r; raster_nxt = raster_r; frame_nxt = frame_r;
    rate50_nxt = rate50_r; mode_nxt = mode_r; tattr_nxt = tattr_r;
    fg_nxt = fg_r; bg_nxt = bg_r; blink_nxt = blink_r; chl_nxt = chl_r;
    y_nxt = y_r; col_nxt = col_r; wrap_nxt = wrap_r; c_nxt = c_r;
    data_nxt = data_r; res_nxt = res_r; rv_nxt = rv_r;
    q_ready = 1'b0; rd_en = 1'b0; rd_addr = scr_addr[MemAddrBits-1:0];
    if (rv_r && res_ready) rv_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid && !q_job.is_write) begin
          logic [8:0] r; logic w; logic r50; logic [8:0] st;
          r = nr; w = 1'b0; r50 = rate50_r;
          if (nr >= maxr) begin
            r = '0; w = 1'b1; frame_nxt = frame_r + 5'd1; r50 = mode_r[1];
          end
          raster_nxt = r; wrap_nxt = w; rate50_nxt = r50;
          st = r50 ? 9'd65 : 9'd32;
          if (r < st || r >= st + 9'd224) begin
            res_nxt = '{pixels: '0, line: '0, column: '0, visible: 1'b0,
                        frame_start: w, last: 1'b1};
            rv_nxt = 1'b1;
            state_nxt = ST_OUTW;
          end else begin
            y_nxt = 8'(r - st);
            chl_nxt = tattr_r[1] ? y_nxt[3:1] : y_nxt[2:0];
            fg_nxt = 3'd7; bg_nxt = 3'd0; tattr_nxt = 3'd0; blink_nxt = 6'h3f;
            col_nxt = '0;
            state_nxt = ST_SCR;
          end
        end
      end
      ST_SCR: begin
        // issue screen read; data lands in rd_r next cycle
        rd_en = 1'b1;
        state_nxt = ST_CHR;
      end
      ST_CHR: begin
        c_nxt = rd_r;
        if (rd_r[6:5] == 2'b00) begin
          unique case (rd_r[4:3])
            ATTR_FG:   fg_nxt = rd_r[2:0];
            ATTR_TEXT: begin
              tattr_nxt = rd_r[2:0];
              blink_nxt = rd_r[2] ? 6'h00 : 6'h3f;
              chl_nxt   = rd_r[1] ? y_r[3:1] : y_r[2:0];
            end
            ATTR_BG:   bg_nxt = rd_r[2:0];
            default:   mode_nxt = rd_r[2:0];
          endcase
          data_nxt = '0;
          state_nxt = ST_EMIT;
        end else if (hires) begin
          data_nxt = rd_r[5:0] & mask;
          state_nxt = ST_EMIT;
        end else begin
          rd_en = 1'b1; rd_addr = chr_addr[MemAddrBits-1:0];
          data_nxt = 6'h3f;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!rv_r || res_ready) begin
          logic [5:0] d;
          d = data_r;
          if (c_r[6:5] != 2'b00 && !hires) d = rd_r[5:0] & mask;
          res_nxt = '{pixels: make_pixels(d, f, g), line: y_r, column: col_r,
                      visible: 1'b1, frame_start: wrap_r,
                      last: (col_r == 6'(CellsPerLine-1))};
          rv_nxt = 1'b1;
          if (col_r == 6'(CellsPerLine-1)) state_nxt = ST_OUTW;
          else begin
            col_nxt = col_r + 6'd1;
            state_nxt = ST_SCR;
          end
        end
      end
      ST_OUTW: begin
        if (!rv_nxt) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; raster_r <= '0; frame_r <= '0; rate50_r <= 1'b1;
      mode_r <= 3'd2; tattr_r <= '0; rv_r <= 1'b0;
    end else begin
      state_r <= state_nxt; raster_r <= raster_nxt; frame_r <= frame_nxt;
      rate50_r <= rate50_nxt; mode_r <= mode_nxt; tattr_r <= tattr_nxt;
      rv_r <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fg_r <= fg_nxt; bg_r <= bg_nxt; blink_r <= blink_nxt; chl_r <= chl_nxt;
    y_r <= y_nxt; col_r <= col_nxt; wrap_r <= wrap_nxt; c_r <= c_nxt;
    data_r <= data_nxt; res_r <= res_nxt;
  end
endmodule

// ----- rtl/core/serial_attribute_video_raster_top.sv -----
// Top level of the serial attribute video raster generator.
// Depends on savr_pkg, savr_front and savr_back.
//
//  channel | handshake           | payload
//  in      | in_valid/in_ready   | in_cmd, in_mem_addr, in_mem_data
//  out     | out_valid/out_ready | out_pixels, out_line, out_column, flags
//  cfg     | APB psel/penable    | four 16-bit base address registers
//
// A memory write is done while the back end is idle. A visible raster line
// runs each cell through a screen read, a charset read or wait, and an
// emit; the single video memory read port keeps the two reads apart, and
// the next job is taken once the last result of the line is accepted. An
// invisible line skips the cell steps. Reset is synchronous, active low;
// video memory is not cleared. The two-entry job queue accepts until full as
// the back end renders; the back end holds in its emit step on out_ready low.
module serial_attribute_video_raster_top import savr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_mem_addr,
  input  logic [7:0]  in_mem_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [17:0] out_pixels,
  output logic [7:0]  out_line,
  output logic [5:0]  out_column,
  output logic        out_visible,
  output logic        out_frame_start,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic        q_valid, q_ready;
  savr_job_t   q_job;
  savr_res_t   res;
  logic [15:0] hscr_r, hchr_r, tscr_r, tchr_r;

  assign pready = 1'b1;

  // Write a base register on the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hscr_r <= 16'd40960; hchr_r <= 16'd38912;
      tscr_r <= 16'd48000; tchr_r <= 16'd46080;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_HSCR: hscr_r <= pwdata[15:0];
        REG_HCHR: hchr_r <= pwdata[15:0];
        REG_TSCR: tscr_r <= pwdata[15:0];
        default:  tchr_r <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HSCR: prdata = {16'd0, hscr_r};
      REG_HCHR: prdata = {16'd0, hchr_r};
      REG_TSCR: prdata = {16'd0, tscr_r};
      default:  prdata = {16'd0, tchr_r};
    endcase
  end

  savr_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_mem_addr, .in_mem_data,
    .q_valid, .q_ready, .q_job
  );

  savr_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_job,
    .hscr(hscr_r), .hchr(hchr_r), .tscr(tscr_r), .tchr(tchr_r),
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign out_pixels      = res.pixels;
  assign out_line        = res.line;
  assign out_column      = res.column;
  assign out_visible     = res.visible;
  assign out_frame_start = res.frame_start;
  assign out_last        = res.last;
endmodule

// ----- rtl/core/savr_checker.sv -----
// Port checker for the serial attribute video raster block, with its bind.
// Depends on serial_attribute_video_raster_top_assert.svh.
`include "serial_attribute_video_raster_top_assert.svh"
module savr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [17:0] out_pixels,
  input logic [7:0]  out_line,
  input logic [5:0]  out_column,
  input logic        out_visible,
  input logic        out_last,
  input logic        pready
);
  `SAVR_ASSERT_IMPL(a_invis, clk, rst_n, out_valid && !out_visible, out_last && out_pixels == 18'd0)
  `SAVR_ASSERT_IMPL(a_lastcol, clk, rst_n, out_valid && out_visible, out_last == (out_column == 6'd39))
  `SAVR_ASSERT_IMPL(a_line, clk, rst_n, out_valid && out_visible, out_line < 8'd224)
  `SAVR_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pixels))
  `SAVR_ASSERT_IMPL(a_pready, clk, rst_n, 1'b1, pready)
endmodule

bind serial_attribute_video_raster_top savr_checker u_savr_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_pixels, .out_line, .out_column,
  .out_visible, .out_last, .pready
);

// ----- tb/sv/serial_attribute_video_raster_top_tb.sv -----
// Self-checking testbench for the serial attribute video raster generator.
// Depends on savr_pkg and serial_attribute_video_raster_top; carries its own raster predictor.
module serial_attribute_video_raster_top_tb;
  import savr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = CMD_WRITE;
  logic [15:0] in_mem_addr = '0;
  logic [7:0]  in_mem_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [17:0] out_pixels;
  logic [7:0]  out_line;
  logic [5:0]  out_column;
  logic        out_visible;
  logic        out_frame_start;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  serial_attribute_video_raster_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_mem_addr(in_mem_addr), .in_mem_data(in_mem_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixels(out_pixels),
    .out_line(out_line), .out_column(out_column), .out_visible(out_visible),
    .out_frame_start(out_frame_start), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: video memory with a written flag per byte, raster
  // counters, mode and attributes, and the four base registers.
  logic [7:0]  vmem [0:65535];
  bit          vmem_set [0:65535];
  logic [8:0]  pm_line;
  logic [4:0]  pm_frames;
  bit          pm_rate50;
  logic [2:0]  pm_mode;
  logic [2:0]  pm_attrs;
  logic [15:0] pm_base [0:3];

  savr_res_t   pending_blocks [$];
  int          fail_count = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  bit          hires_on = 1'b0;
  int          hold_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL serial_attribute_video_raster_top");
    $finish;
  end

  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (stalls_on) begin
      out_ready <= ($urandom_range(99) >= 33);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every transfer on the result channel with the oldest expectation.
  always @(posedge clk) begin
    savr_res_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_pixels, out_line, out_column, out_visible, out_frame_start, out_last};
      if (pending_blocks.size() == 0) begin
        $display("%0t: unexpected block px=%h line=%0d col=%0d vis=%b fs=%b last=%b",
                 $time, got.pixels, got.line, got.column, got.visible,
                 got.frame_start, got.last);
        fail_count++;
      end else begin
        want = pending_blocks.pop_front();
        if (got !== want) begin
          $display("%0t: expected px=%h line=%0d col=%0d vis=%b fs=%b last=%b", $time,
                   want.pixels, want.line, want.column, want.visible,
                   want.frame_start, want.last);
          $display("%0t:   actual px=%h line=%0d col=%0d vis=%b fs=%b last=%b", $time,
                   got.pixels, got.line, got.column, got.visible,
                   got.frame_start, got.last);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [17:0] expand_cell(logic [5:0] bits, logic [2:0] on_c,
                                              logic [2:0] off_c);
    logic [17:0] px;
    px = '0;
    for (int i = 0; i < 6; i++) px = {px[14:0], bits[5-i] ? on_c : off_c};
    return px;
  endfunction

  // Predict one raster step. If any byte it would read was never written,
  // return that address in miss and leave the state untouched; otherwise
  // commit the new state and queue the expected blocks.
  task automatic predict_raster(output int miss);
    logic [8:0]  rl;
    logic [4:0]  fc;
    bit          rate, wrapped, hires;
    logic [2:0]  mode, attrs, fg, bg, f, g, v;
    logic [15:0] a;
    logic [7:0]  c, d, mask, blink;
    int          start, y, cy, chline, cb;
    savr_res_t   row [CellsPerLine];
    miss = -1;
    rl = pm_line + 9'd1;
    fc = pm_frames;
    rate = pm_rate50;
    wrapped = 1'b0;
    if (rl >= (rate ? 312 : 262)) begin
      rl = '0;
      wrapped = 1'b1;
      fc = fc + 5'd1;
      rate = pm_mode[1];
    end
    start = rate ? 65 : 32;
    mode = pm_mode;
    attrs = pm_attrs;
    if (rl < start || rl >= start + 224) begin
      pending_blocks.push_back('{18'd0, 8'd0, 6'd0, 1'b0, wrapped, 1'b1});
    end else begin
      y = rl - start;
      cy = (y >> 3) * CellsPerLine;
      // Row comes from the attributes left by the previous line.
      chline = attrs[1] ? ((y >> 1) & 7) : (y & 7);
      fg = 3'd7;
      bg = 3'd0;
      attrs = '0;
      blink = 8'h3f;
      for (int b = 0; b < CellsPerLine; b++) begin
        hires = (y < 200) && mode[2];
        if (hires) a = 16'(pm_base[REG_HSCR] + y * CellsPerLine + b);
        else a = 16'(pm_base[REG_TSCR] + cy + b);
        if (!vmem_set[a]) begin
          miss = a;
          return;
        end
        c = vmem[a];
        if (c[6:5] == 2'b00) begin
          v = c[2:0];
          case (c[4:3])
            ATTR_FG: fg = v;
            ATTR_TEXT: begin
              attrs = v;
              blink = v[2] ? 8'h00 : 8'h3f;
              chline = v[1] ? ((y >> 1) & 7) : (y & 7);
            end
            ATTR_BG: bg = v;
            default: mode = v;
          endcase
          d = '0;
        end else begin
          mask = fc[4] ? 8'h3f : blink;
          if (hires) begin
            d = c & mask;
          end else begin
            cb = mode[2] ? pm_base[REG_HCHR] : pm_base[REG_TCHR];
            if (attrs[0]) cb += 1024;
            a = 16'(cb + (c[6:0] << 3) + chline);
            if (!vmem_set[a]) begin
              miss = a;
              return;
            end
            d = vmem[a] & mask;
          end
        end
        f = c[7] ? ~fg : fg;
        g = c[7] ? ~bg : bg;
        row[b].pixels = expand_cell(d[5:0], f, g);
        row[b].line = 8'(y);
        row[b].column = 6'(b);
        row[b].visible = 1'b1;
        row[b].frame_start = wrapped;
        row[b].last = (b == CellsPerLine - 1);
      end
      foreach (row[i]) pending_blocks.push_back(row[i]);
    end
    pm_line = rl;
    pm_frames = fc;
    pm_rate50 = rate;
    pm_mode = mode;
    pm_attrs = attrs;
  endtask

  // Offer one item and hold it until the transfer happens.
  task automatic offer_item(logic cmd, logic [15:0] a, logic [7:0] d);
    if (gaps_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_mem_addr <= a;
    in_mem_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_write(logic [15:0] a, logic [7:0] d);
    vmem[a] = d;
    vmem_set[a] = 1'b1;
    offer_item(CMD_WRITE, a, d);
  endtask

  // Mostly a few printable codes, so charset rows get reused, with a fair
  // share of attributes; hires mode only when a test allows it.
  function automatic logic [7:0] fill_byte();
    logic [7:0] d;
    d = 8'($urandom);
    if ($urandom_range(99) < 70) begin
      d[6:0] = 7'h41 + 7'($urandom_range(3));
    end else begin
      d[6:5] = 2'b00;
      if (d[4:3] == ATTR_MODE && !hires_on) d[2] = 1'b0;
    end
    return d;
  endfunction

  // Write every byte the next line would read, then advance one line.
  task automatic send_raster();
    int miss;
    predict_raster(miss);
    while (miss >= 0) begin
      send_write(16'(miss), fill_byte());
      predict_raster(miss);
    end
    offer_item(CMD_RASTER, 16'($urandom), 8'($urandom));
  endtask

  task automatic run_lines(int n, int noise_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) send_write(16'($urandom), 8'($urandom));
      send_raster();
    end
  endtask

  // Drain all expected blocks, then let the job queue run dry.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pm_base[idx] = val;
  endtask

  task automatic set_bases(logic [15:0] hs, logic [15:0] hc, logic [15:0] ts,
                           logic [15:0] tc);
    settle();
    cfg_write(REG_HSCR, hs);
    cfg_write(REG_HCHR, hc);
    cfg_write(REG_TSCR, ts);
    cfg_write(REG_TCHR, tc);
    @(posedge clk);
  endtask

  // Extremes of address and data on plain memory writes.
  task automatic test_mem_extremes();
    send_write(16'h0000, 8'h00);
    send_write(16'hffff, 8'hff);
    send_write(16'h0000, 8'hff);
    send_write(16'hffff, 8'h00);
    send_write(16'haaaa, 8'h55);
    send_write(16'h5555, 8'haa);
  endtask

  // Climb through the top border into the first visible lines at the reset
  // bases, no idling.
  task automatic test_reset_frame();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_lines(68, 5);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Bases near the top so screen and charset reads wrap the address space.
  task automatic test_base_wrap();
    set_bases(16'hffff, 16'hfc00, 16'hffe0, 16'hffff);
    run_lines(4, 10);
  endtask

  // Hold the receiver off while lines keep coming, so the block fills and stalls.
  task automatic test_backpressure();
    settle();
    hold_cycles = 600;
    run_lines(4, 0);
  endtask

  task automatic test_random_bases();
    set_bases(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_lines(3, 10);
  endtask

  // Let mode attributes switch to hires in the middle of a line.
  task automatic test_hires();
    hires_on = 1'b1;
    run_lines(2, 0);
    hires_on = 1'b0;
  endtask

  initial begin
    pm_line = '0;
    pm_frames = '0;
    pm_rate50 = 1'b1;
    pm_mode = 3'd2;
    pm_attrs = '0;
    pm_base[REG_HSCR] = 16'd40960;
    pm_base[REG_HCHR] = 16'd38912;
    pm_base[REG_TSCR] = 16'd48000;
    pm_base[REG_TCHR] = 16'd46080;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_mem_extremes();
    test_reset_frame();
    test_base_wrap();
    test_random_bases();
    test_backpressure();
    test_hires();
    settle();
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS serial_attribute_video_raster_top");
    end else begin
      $display("FAIL serial_attribute_video_raster_top");
    end
    $finish;
  end
endmodule
